// ----- rtl/cph_pkg.sv -----
// Package for the cascaded PID homing controller.
// Types, constants and the sequencer state enum; no dependencies.
package cph_pkg;

  localparam int GAIN_W = 16;
  localparam int TGT_W  = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;
  localparam int ACC_W  = 56;

  localparam logic [CFG_IDX_W-1:0] REG_POS_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAN_KI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_TGT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RET_TGT = 3'd7;

  localparam logic [1:0] KEY_Z = 2'd1;
  localparam logic [1:0] KEY_X = 2'd2;

  localparam int VEL_HOME_TGT = -1000;
  localparam int VEL_SUM_LIM  = 3000;
  localparam int POS_OUT_LIM  = 2000;
  localparam int DRV_LIM      = 8000;
  localparam int STALL_LIM    = 5000;
  localparam int HOME_DRV_LIM = -2000;
  localparam int DEAD_BAND    = 4;

  // multiplier operand select
  typedef enum logic [2:0] {
    MUL_POS_P, MUL_POS_I, MUL_POS_D, MUL_VEL_P, MUL_VEL_I, MUL_VEL_D
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VPREP, ST_VP, ST_VI, ST_VD, ST_VOUT,
    ST_PPREP, ST_PP, ST_PI, ST_PD, ST_POUT, ST_DONE
  } state_t;

  typedef struct packed {
    logic     clr;
    logic     en;
    mul_sel_t sel;
  } mac_ctl_t;

endpackage

// ----- rtl/cph_if.sv -----
// Valid/ready stream interface carrying a payload of type T.
// Depends on nothing.
interface cph_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cascaded_pid_homing_controller_core.sv -----
// Top level of the cascaded position/velocity PID homing controller.
// Depends on cph_pkg, cph_if and cph_mac.
//
// Usage:
//   in  channel : speed, angle, key for one control tick (valid/ready).
//   out channel : drive, back_flag, send_stop, homed (valid/ready).
//   cfg port    : cfg_we, cfg_idx, cfg_data write one gain or target.
// Each tick is worked by a sequencer around one shared multiply-accumulate
// unit: three products per PID. A homing tick runs the velocity loop, a
// homed tick the position loop and then the velocity loop, and the tick on
// which homing completes runs the velocity loop twice with the position
// loop between. A new item is taken the cycle after the result has been
// transferred out. Reset (synchronous, rst_n low) restores the register
// defaults and clears the sequencer, flags, counters and integrators;
// the block comes up ready in the homing phase.
// When the receiver stalls, the result holds on out and in_ready stays low.
module cascaded_pid_homing_controller_core #(
  parameter int HOME_STALL_TICKS  = 50,
  parameter int ROTOR_STALL_TICKS = 150,
  parameter int ENCODER_BITS      = 13
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cph_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [cph_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_speed,
  input  logic [12:0]                        in_angle,
  input  logic [1:0]                         in_key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [13:0]                 out_drive,
  output logic                               out_back_flag,
  output logic                               out_send_stop,
  output logic                               out_homed
);
  import cph_pkg::*;

  localparam int EB = ENCODER_BITS;
  localparam logic [EB-1:0] EMASK = {EB{1'b1}};

  typedef struct packed {
    logic signed [15:0] speed;
    logic [12:0]        angle;
    logic [1:0]         key;
  } in_item_t;
  typedef struct packed {
    logic signed [13:0] drive;
    logic               back_flag;
    logic               send_stop;
    logic               homed;
  } out_item_t;

  cph_if #(.T(in_item_t))  in_ch ();
  cph_if #(.T(out_item_t)) out_ch ();
  assign in_ch.valid = in_valid;
  assign in_ch.data  = '{speed: in_speed, angle: in_angle, key: in_key};
  assign in_ready    = in_ch.ready;
  assign out_valid   = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_drive     = out_ch.data.drive;
  assign out_back_flag = out_ch.data.back_flag;
  assign out_send_stop = out_ch.data.send_stop;
  assign out_homed     = out_ch.data.homed;

  // configuration
  logic [15:0] pos_kp_r, pos_ki_r, pos_kd_r, vel_kp_r, vel_kd_r, can_ki_r;
  logic [TGT_W-1:0] ext_tgt_r, ret_tgt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r <= 16'd1188; pos_ki_r <= '0; pos_kd_r <= '0;
      vel_kp_r <= 16'd9830; vel_kd_r <= '0; can_ki_r <= 16'd410;
      ext_tgt_r <= 18'd78000; ret_tgt_r <= 18'd28000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POS_KP:  pos_kp_r  <= cfg_data[15:0];
        REG_POS_KI:  pos_ki_r  <= cfg_data[15:0];
        REG_POS_KD:  pos_kd_r  <= cfg_data[15:0];
        REG_VEL_KP:  vel_kp_r  <= cfg_data[15:0];
        REG_VEL_KD:  vel_kd_r  <= cfg_data[15:0];
        REG_CAN_KI:  can_ki_r  <= cfg_data[15:0];
        REG_EXT_TGT: ext_tgt_r <= cfg_data;
        REG_RET_TGT: ret_tgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // loop state
  state_t state_r, state_nxt;
  logic homed_r, back_r, stop_r;
  logic [5:0] hcnt_r;
  logic [7:0] rcnt_r;
  logic [2:0] zs_r, xs_r;
  logic [15:0] vki_r;
  logic [TGT_W-1:0] ptgt_r;
  logic [31:0] loc_r;
  logic [EB-1:0] lang_r;
  logic signed [32:0] perr_last_r, perr_r;
  logic signed [31:0] psum_r;
  logic signed [17:0] verr_last_r, verr_r;
  logic signed [12:0] vsum_r;
  logic signed [12:0] vtgt_r;
  logic signed [13:0] drive_r;
  in_item_t item_r;
  logic ovalid_r;

  // encoder angle taken to the configured encoder width
  logic [EB-1:0] ang_e;
  assign ang_e = EB'(item_r.angle);

  // MAC
  mac_ctl_t mctl;
  logic [15:0] mgain;
  logic signed [39:0] mterm;
  logic signed [ACC_W-1:0] acc;
  cph_mac u_mac (.clk(clk), .ctl(mctl), .gain(mgain), .term(mterm), .acc(acc));

  always_comb begin
    unique case (mctl.sel)
      MUL_POS_P: begin mgain = pos_kp_r; mterm = 40'(perr_r); end
      MUL_POS_I: begin mgain = pos_ki_r; mterm = 40'(psum_r); end
      MUL_POS_D: begin mgain = pos_kd_r; mterm = 40'(perr_r) - 40'(perr_last_r); end
      MUL_VEL_P: begin mgain = vel_kp_r; mterm = 40'(verr_r); end
      MUL_VEL_I: begin mgain = vki_r;    mterm = 40'(vsum_r); end
      MUL_VEL_D: begin mgain = vel_kd_r; mterm = 40'(verr_r) - 40'(verr_last_r); end
      default:   begin mgain = '0;       mterm = '0; end
    endcase
  end

  // rounding: floor((acc + 2048) / 4096), shift is arithmetic floor
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-13:0] rnd;
  assign rnd_sum = acc + ACC_W'(2048);
  assign rnd = rnd_sum[ACC_W-1:12];

  // velocity error prep
  logic signed [15:0] pv;
  logic signed [17:0] verr_c;
  logic signed [18:0] vsum_c;
  logic signed [12:0] vsum_cl;
  assign pv = (item_r.speed >= -16'sd4 && item_r.speed <= 16'sd4) ? 16'sd0
              : item_r.speed;
  assign verr_c = 18'(vtgt_r) - 18'(pv);
  assign vsum_c = 19'(vsum_r) + 19'(verr_c);
  assign vsum_cl = (vsum_c > 19'sd3000) ? 13'sd3000 :
                   (vsum_c < -19'sd3000) ? -13'sd3000 : 13'(vsum_c);

  // velocity output with stall handling
  logic signed [13:0] vout_c, vout_f;
  logic [7:0] rcnt_c;
  always_comb begin
    if (rnd > 44'sd8000) vout_c = 14'sd8000;
    else if (rnd < -44'sd8000) vout_c = -14'sd8000;
    else vout_c = 14'(rnd);
    rcnt_c = rcnt_r;
    vout_f = vout_c;
    if (item_r.speed == 16'sd0 && (vout_c > 14'sd5000 || vout_c < -14'sd5000)
        && rcnt_c != 8'd255)
      rcnt_c = rcnt_c + 8'd1;
    if (32'(rcnt_c) >= ROTOR_STALL_TICKS) begin
      rcnt_c = 8'(ROTOR_STALL_TICKS);
      if (vout_f > 14'sd5000) vout_f = 14'sd5000;
      else if (vout_f < -14'sd5000) vout_f = -14'sd5000;
    end
    if (vout_f < 14'sd5000 && vout_f > -14'sd5000) rcnt_c = '0;
  end

  // position prep: keys, encoder delta, error
  logic [2:0] zs_c, xs_c;
  logic back_c, stop_c;
  logic [15:0] vki_c;
  logic [TGT_W-1:0] ptgt_c;
  logic [EB-1:0] d;
  logic [31:0] loc_c;
  logic signed [32:0] perr_c;
  logic signed [33:0] psum_w;
  logic signed [31:0] psum_c;
  logic kz, kx;
  assign kz = (item_r.key == KEY_Z);
  assign kx = (item_r.key == KEY_X);
  always_comb begin
    zs_c = zs_r; xs_c = xs_r; back_c = back_r; stop_c = 1'b0;
    vki_c = vki_r; ptgt_c = ptgt_r;
    if (kz && zs_c == 3'd0) begin back_c = 1'b1; zs_c = 3'd1; ptgt_c = ret_tgt_r; xs_c = 3'd0; end
    if (!kz && zs_c == 3'd1) zs_c = 3'd2;
    if (kz && zs_c == 3'd2) begin vki_c = '0; ptgt_c = '0; zs_c = 3'd3; end
    if (!kz && zs_c == 3'd3) zs_c = 3'd4;
    if (kz && zs_c == 3'd4) zs_c = 3'd5;
    if (!kz && zs_c == 3'd5) begin back_c = 1'b0; stop_c = 1'b1; zs_c = 3'd0; end
    if (kx && xs_c == 3'd0) begin back_c = 1'b1; zs_c = 3'd0; xs_c = 3'd1; end
    if (!kx && xs_c == 3'd1) xs_c = 3'd2;
    if (kx && xs_c == 3'd2) begin vki_c = can_ki_r; ptgt_c = ext_tgt_r; xs_c = 3'd3; end
    if (!kx && xs_c == 3'd3) xs_c = 3'd4;
    if (kx && xs_c == 3'd4) begin back_c = 1'b0; xs_c = 3'd5; end
    if (!kx && xs_c == 3'd5) begin stop_c = 1'b1; xs_c = 3'd0; end
    d = (ang_e - lang_r) & EMASK;
    loc_c = loc_r + 32'($signed(d));
    perr_c = $signed({15'd0, ptgt_c}) - 33'($signed(loc_c));
    psum_w = 34'(psum_r) + 34'(perr_c);
    if (psum_w > 34'sh07fffffff) psum_c = 32'sh7fffffff;
    else if (psum_w < -34'sh080000000) psum_c = 32'sh80000000;
    else psum_c = 32'(psum_w);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid && in_ch.ready) state_nxt = homed_r ? ST_PPREP : ST_VPREP;
      ST_VPREP: state_nxt = ST_VP;
      ST_VP:    state_nxt = ST_VI;
      ST_VI:    state_nxt = ST_VD;
      ST_VD:    state_nxt = ST_VOUT;
      ST_VOUT: begin
        if (!homed_r && item_r.speed == 16'sd0 && vout_f < 14'(HOME_DRV_LIM)
            && 32'(hcnt_r) + 1 > HOME_STALL_TICKS)
          state_nxt = ST_PPREP;
        else state_nxt = ST_DONE;
      end
      ST_PPREP: state_nxt = ST_PP;
      ST_PP:    state_nxt = ST_PI;
      ST_PI:    state_nxt = ST_PD;
      ST_PD:    state_nxt = ST_POUT;
      ST_POUT:  state_nxt = ST_VPREP;
      ST_DONE:  if (!ovalid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // MAC control
  always_comb begin
    mctl = '{clr: 1'b0, en: 1'b0, sel: MUL_VEL_P};
    unique case (state_r)
      ST_VP: mctl = '{clr: 1'b1, en: 1'b1, sel: MUL_VEL_P};
      ST_VI: mctl = '{clr: 1'b0, en: 1'b1, sel: MUL_VEL_I};
      ST_VD: mctl = '{clr: 1'b0, en: 1'b1, sel: MUL_VEL_D};
      ST_PP: mctl = '{clr: 1'b1, en: 1'b1, sel: MUL_POS_P};
      ST_PI: mctl = '{clr: 1'b0, en: 1'b1, sel: MUL_POS_I};
      ST_PD: mctl = '{clr: 1'b0, en: 1'b1, sel: MUL_POS_D};
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = '{drive: drive_r, back_flag: back_r, send_stop: stop_r,
                         homed: homed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ovalid_r <= 1'b0; homed_r <= 1'b0; back_r <= 1'b0;
      stop_r <= 1'b0; hcnt_r <= '0; rcnt_r <= '0; zs_r <= '0; xs_r <= '0;
      vki_r <= '0; ptgt_r <= '0; loc_r <= '0; lang_r <= '0;
      perr_last_r <= '0; psum_r <= '0; verr_last_r <= '0; vsum_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          item_r <= in_ch.data;
          stop_r <= 1'b0;
          vtgt_r <= 13'(VEL_HOME_TGT);
        end
        ST_VPREP: begin
          verr_r <= verr_c;
          vsum_r <= vsum_cl;
        end
        ST_VOUT: begin
          verr_last_r <= verr_r;
          rcnt_r <= rcnt_c;
          drive_r <= vout_f;
          if (!homed_r && item_r.speed == 16'sd0 && vout_f < 14'(HOME_DRV_LIM)) begin
            if (32'(hcnt_r) + 1 > HOME_STALL_TICKS) begin
              homed_r <= 1'b1; hcnt_r <= '0;
              lang_r <= ang_e;
              ptgt_r <= ext_tgt_r;
            end else hcnt_r <= hcnt_r + 6'd1;
          end
        end
        ST_PPREP: begin
          zs_r <= zs_c; xs_r <= xs_c; back_r <= back_c; stop_r <= stop_c;
          vki_r <= vki_c; ptgt_r <= ptgt_c; loc_r <= loc_c;
          perr_r <= perr_c; psum_r <= psum_c;
          lang_r <= ang_e;
        end
        ST_POUT: begin
          perr_last_r <= perr_r;
          if (rnd > 44'sd2000) vtgt_r <= 13'sd2000;
          else if (rnd < -44'sd2000) vtgt_r <= -13'sd2000;
          else vtgt_r <= 13'(rnd);
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/cph_mac.sv -----
// Shared multiply-accumulate unit: one unsigned 16 x signed 40 product per cycle while ctl.en is high.
// Depends on cph_pkg.
module cph_mac (
  input  logic                     clk,
  input  cph_pkg::mac_ctl_t        ctl,
  input  logic [15:0]              gain,
  input  logic signed [39:0]       term,
  output logic signed [cph_pkg::ACC_W-1:0] acc
);
  import cph_pkg::*;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod;

  // split the wide operand into two partial products
  logic signed [16:0] g;
  logic signed [ACC_W-1:0] p_lo, p_hi;
  always_comb begin
    g    = $signed({1'b0, gain});
    p_lo = ACC_W'(g * $signed({1'b0, term[19:0]}));
    p_hi = ACC_W'(g * $signed(term[39:20])) <<< 20;
    prod = p_lo + p_hi;
    acc_nxt = ctl.clr ? prod : acc_r + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) acc_r <= acc_nxt;
  end
  assign acc = acc_r;
endmodule
